FILE: rtl/twtp_pkg.sv
// Shared types and constants for the three-way threshold partition block.
// No dependencies; the top level imports it.
package twtp_pkg;

  localparam int DATA_W = 32;
  localparam int GRP_W  = 2;
  localparam int ADDR_W = 3;

  localparam logic [DATA_W-1:0] HIGH_RESET = 32'd1000;
  localparam logic [DATA_W-1:0] LOW_RESET  = 32'd700;

  // register index as seen on paddr[2]
  localparam logic REG_HIGH = 1'b0;
  localparam logic REG_LOW  = 1'b1;

  localparam logic [GRP_W-1:0] GRP_HIGH = 2'd0;
  localparam logic [GRP_W-1:0] GRP_MID  = 2'd1;
  localparam logic [GRP_W-1:0] GRP_REST = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO_RD,
    ST_LO_CHK,
    ST_HI_RD,
    ST_HI_CHK,
    ST_SWAP,
    ST_EM_RD,
    ST_EM_OUT
  } state_t;

endpackage

FILE: rtl/three_way_threshold_partition.sv
// Three-way threshold partition: value buffer, two-pointer partition sequencer,
// emit walk and APB threshold registers. Depends on twtp_pkg.
//
// Loading: one word per cycle while busy is low; a word without the final mark
//   never raises busy. The final word starts the partition: two passes of
//   pointer steps and swaps through the value buffer, each using the shared
//   compare unit, then the emit walk, which reads each stored word and then
//   presents it as a result. Results cannot be stalled.
// Reset (synchronous): thresholds to 1000/700, fill count and overflow cleared,
//   sequencer idle; buffer contents are not cleared.
module three_way_threshold_partition #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // item side
  input  logic                          start,
  output logic                          busy,
  input  logic [twtp_pkg::DATA_W-1:0]   item_value,
  input  logic                          is_final,
  // result side
  output logic                          result_strobe,
  output logic [twtp_pkg::DATA_W-1:0]   out_value,
  output logic [twtp_pkg::GRP_W-1:0]    group_code,
  output logic                          end_of_run,
  output logic                          overflowed,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twtp_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import twtp_pkg::*;

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  // threshold registers
  logic [DATA_W-1:0] high_thr;
  logic [DATA_W-1:0] low_thr;

  // value buffer
  logic [DATA_W-1:0] value_store [MAX_ITEMS];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] mem_rdata;

  // sequencer registers
  state_t            state, state_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic              ovf, ovf_next;
  logic [IDX_W-1:0]  lo, lo_next;
  logic [IDX_W-1:0]  hi, hi_next;
  logic [DATA_W-1:0] vlo, vlo_next;
  logic              pass_sel, pass_sel_next;
  logic [IDX_W-1:0]  k, k_next;
  logic [GRP_W-1:0]  grp, grp_next;

  // result registers
  logic              strobe_next;
  logic [DATA_W-1:0] out_value_next;
  logic [GRP_W-1:0]  group_code_next;
  logic              end_of_run_next;
  logic              overflowed_next;

  // shared compare unit and helpers
  logic [DATA_W-1:0] limit;
  logic              gt_limit;
  logic              gt_high;
  logic              gt_low;
  logic              has_room;
  logic              pass_end;
  logic              last_k;
  logic [GRP_W-1:0]  grp_s1;
  logic [GRP_W-1:0]  grp_s2;
  logic              cfg_wr;

  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration port: register index lives in paddr[2].
  // ---------------------------------------------------------------------------
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_thr <= HIGH_RESET;
      low_thr  <= LOW_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HIGH) begin
        high_thr <= pwdata;
      end else begin
        low_thr <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_LOW) ? low_thr : high_thr;

  // ---------------------------------------------------------------------------
  // Value buffer: one write and one registered read per cycle.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      value_store[mem_wa] <= mem_wd;
    end
    mem_rdata <= value_store[rd_addr];
  end

  // The pass compare uses the high threshold first, then the low one.
  assign limit    = pass_sel ? low_thr : high_thr;
  assign gt_limit = (mem_rdata > limit);
  assign gt_high  = (mem_rdata > high_thr);
  assign gt_low   = (mem_rdata > low_thr);
  assign has_room = (fill < CNT_W'(MAX_ITEMS));
  assign last_k   = ((CNT_W'(k) + CNT_W'(1)) == fill);

  // Group tag follows a forward walk: high run, then mid run, then the rest.
  assign grp_s1 = ((grp == GRP_HIGH) && !gt_high) ? GRP_MID : grp;
  assign grp_s2 = ((grp_s1 == GRP_MID) && !gt_low) ? GRP_REST : grp_s1;

  // ---------------------------------------------------------------------------
  // Sequencer: load, two Hoare-style passes, emit walk.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill          <= '0;
      ovf           <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      fill          <= fill_next;
      ovf           <= ovf_next;
      result_strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    vlo        <= vlo_next;
    pass_sel   <= pass_sel_next;
    k          <= k_next;
    grp        <= grp_next;
    out_value  <= out_value_next;
    group_code <= group_code_next;
    end_of_run <= end_of_run_next;
    overflowed <= overflowed_next;
  end

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    ovf_next        = ovf;
    lo_next         = lo;
    hi_next         = hi;
    vlo_next        = vlo;
    pass_sel_next   = pass_sel;
    k_next          = k;
    grp_next        = grp;
    strobe_next     = 1'b0;
    out_value_next  = out_value;
    group_code_next = group_code;
    end_of_run_next = end_of_run;
    overflowed_next = overflowed;
    mem_we          = 1'b0;
    mem_wa          = lo;
    mem_wd          = vlo;
    rd_addr         = lo;
    pass_end        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (has_room) begin
            mem_we    = 1'b1;
            mem_wa    = fill[IDX_W-1:0];
            mem_wd    = item_value;
            fill_next = fill + CNT_W'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (is_final) begin
            pass_sel_next = 1'b0;
            lo_next       = '0;
            // last stored index: old fill when the word fit, else the top slot
            hi_next       = has_room ? fill[IDX_W-1:0] : IDX_W'(MAX_ITEMS - 1);
            state_next    = ST_LO_RD;
          end
        end
      end

      ST_LO_RD: begin
        if (lo < hi) begin
          rd_addr    = lo;
          state_next = ST_LO_CHK;
        end else begin
          pass_end = 1'b1;
        end
      end

      ST_LO_CHK: begin
        if (gt_limit) begin
          lo_next    = lo + IDX_W'(1);
          state_next = ST_LO_RD;
        end else begin
          vlo_next   = mem_rdata;
          state_next = ST_HI_RD;
        end
      end

      ST_HI_RD: begin
        if (lo < hi) begin
          rd_addr    = hi;
          state_next = ST_HI_CHK;
        end else begin
          pass_end = 1'b1;
        end
      end

      ST_HI_CHK: begin
        if (!gt_limit) begin
          hi_next    = hi - IDX_W'(1);
          state_next = ST_HI_RD;
        end else begin
          // first half of the swap: high-side word goes to lo
          mem_we     = 1'b1;
          mem_wa     = lo;
          mem_wd     = mem_rdata;
          state_next = ST_SWAP;
        end
      end

      ST_SWAP: begin
        mem_we     = 1'b1;
        mem_wa     = hi;
        mem_wd     = vlo;
        lo_next    = lo + IDX_W'(1);
        hi_next    = hi - IDX_W'(1);
        state_next = ST_LO_RD;
      end

      ST_EM_RD: begin
        rd_addr    = k;
        state_next = ST_EM_OUT;
      end

      ST_EM_OUT: begin
        strobe_next     = 1'b1;
        out_value_next  = mem_rdata;
        group_code_next = grp_s2;
        grp_next        = grp_s2;
        end_of_run_next = last_k;
        overflowed_next = last_k && ovf;
        if (last_k) begin
          fill_next  = '0;
          ovf_next   = 1'b0;
          state_next = ST_IDLE;
        end else begin
          k_next     = k + IDX_W'(1);
          state_next = ST_EM_RD;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Pointers met: rerun with the low threshold, or start the emit walk.
    if (pass_end) begin
      if (!pass_sel) begin
        pass_sel_next = 1'b1;
        lo_next       = '0;
        hi_next       = IDX_W'(fill - CNT_W'(1));
        state_next    = ST_LO_RD;
      end else begin
        k_next     = '0;
        grp_next   = GRP_HIGH;
        state_next = ST_EM_RD;
      end
    end
  end

endmodule
